// ===== rtl/text_console_writer_macros.svh =====
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS = 90;
    localparam int ROWS    = 30;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int OP_W        = 3;
    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int ENTRY_W     = 16;
    localparam int COLOR_W     = 4;

    localparam logic [COLOR_W-1:0] COLOR_RESET  = 4'd7;
    localparam logic [ENTRY_W-1:0] BLANK_ENTRY  = 16'h0720;
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_BACKSPACE  = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_SET_CURSOR = 3'd3,
        OP_READ_CELL  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_PUT,
        K_NEWLINE,
        K_BACKSPACE,
        K_CLEAR,
        K_SET,
        K_READ
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RUN,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              in_range;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(32'(row) * COLUMNS + 32'(col));
    endfunction

endpackage

// ===== rtl/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2700
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcw_front.sv =====
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; (
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [CHAR_W-1:0]      s_char_code,
    input  logic [ROW_FIELD_W-1:0] s_target_row,
    input  logic [COL_FIELD_W-1:0] s_target_column,
    input  logic                   init_busy,
    input  queue_status_t          q_status,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic row_ok;
    logic col_ok;

    assign s_ready = !q_status.full && !init_busy;
    assign push    = s_valid && s_ready;

    assign row_ok = 32'(s_target_row) < ROWS;
    assign col_ok = 32'(s_target_column) < COLUMNS;

    always_comb begin
        push_cmd.char_code = s_char_code;
        push_cmd.in_range  = row_ok && col_ok;
        // saturate to the last row and column
        push_cmd.row = row_ok ? ROW_W'(s_target_row) : ROW_W'(ROWS - 1);
        push_cmd.col = col_ok ? COL_W'(s_target_column) : COL_W'(COLUMNS - 1);
        unique case (s_operation)
            OP_PUT_CHAR:   push_cmd.kind = (s_char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT;
            OP_BACKSPACE:  push_cmd.kind = K_BACKSPACE;
            OP_CLEAR:      push_cmd.kind = K_CLEAR;
            OP_SET_CURSOR: push_cmd.kind = K_SET;
            OP_READ_CELL:  push_cmd.kind = K_READ;
            default:       push_cmd.kind = K_NOP;
        endcase
    end

endmodule

// ===== rtl/tcw_queue.sv =====
`timescale 1ns / 1ps

module tcw_queue import tcw_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/tcw_back.sv =====
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [COLOR_W-1:0]     cfg_wr_data,
    input  cmd_t                   q_head,
    input  queue_status_t          q_status,
    output logic                   pop,
    output logic                   init_busy,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ENTRY_W-1:0]     m_cell_entry,
    output logic [ROW_FIELD_W-1:0] m_row_now,
    output logic [COL_FIELD_W-1:0] m_column_now
);

    state_t              state_reg,      state_next;
    cmd_t                cmd_reg,        cmd_next;
    logic [ROW_W-1:0]    row_reg,        row_next;
    logic [COL_W-1:0]    col_reg,        col_next;
    logic [COLOR_W-1:0]  color_reg,      color_next;
    logic [ADDR_W-1:0]   sweep_reg,      sweep_next;
    logic                pend_reg,       pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg,  pend_addr_next;
    logic                pend_blank_reg, pend_blank_next;
    logic [ENTRY_W-1:0]  entry_reg,      entry_next;
    logic                m_valid_reg,    m_valid_next;
    logic [ENTRY_W-1:0]  m_entry_reg,    m_entry_next;
    logic [ROW_FIELD_W-1:0] m_row_reg,   m_row_next;
    logic [COL_FIELD_W-1:0] m_col_reg,   m_col_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                sweep_last;
    logic                sweep_copy;
    logic                wrap;
    logic                row_last;
    logic                out_load;

    tcw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sweep_last = (sweep_reg == ADDR_W'(CELLS - 1));
    assign sweep_copy = (32'(sweep_reg) < CELLS - COLUMNS);
    assign row_last   = (row_reg == ROW_W'(ROWS - 1));
    assign wrap       = (cmd_reg.kind == K_NEWLINE) ||
                        (cmd_reg.kind == K_PUT && col_reg == COL_W'(COLUMNS - 1));
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign init_busy  = (state_reg == ST_INIT);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (!q_status.empty) state_next = ST_RUN;
            end
            ST_RUN: begin
                unique case (cmd_reg.kind) inside
                    K_CLEAR:            state_next = ST_CLEAR;
                    K_READ:             state_next = cmd_reg.in_range ? ST_READ_WAIT : ST_DONE;
                    K_PUT, K_NEWLINE:   state_next = (wrap && row_last) ? ST_SCROLL : ST_DONE;
                    default:            state_next = ST_DONE;
                endcase
            end
            ST_READ_WAIT:  state_next = ST_DONE;
            ST_SCROLL: begin
                if (sweep_last) state_next = ST_SCROLL_END;
            end
            ST_SCROLL_END: state_next = ST_DONE;
            ST_CLEAR: begin
                if (sweep_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = q_status.empty ? ST_IDLE : ST_RUN;
            end
            default:       state_next = ST_INIT;
        endcase
    end

    always_comb begin
        pop             = 1'b0;
        row_next        = row_reg;
        col_next        = col_reg;
        color_next      = cfg_wr_en ? cfg_wr_data : color_reg;
        sweep_next      = '0;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_blank_next = pend_blank_reg;
        entry_next      = entry_reg;
        ram_we          = 1'b0;
        ram_waddr       = cell_addr(row_reg, col_reg);
        ram_wdata       = BLANK_ENTRY;
        ram_raddr       = cell_addr(cmd_reg.row, cmd_reg.col);
        m_entry_next    = m_entry_reg;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;

        unique case (state_reg) inside
            ST_INIT, ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                pop = !q_status.empty;
            end
            ST_RUN: begin
                entry_next = '0;
                unique case (cmd_reg.kind) inside
                    K_PUT: begin
                        ram_we    = 1'b1;
                        ram_wdata = {{(ENTRY_W - COLOR_W - CHAR_W){1'b0}}, color_reg,
                                     cmd_reg.char_code};
                        col_next  = col_reg + COL_W'(1);
                    end
                    K_BACKSPACE: begin
                        if (col_reg != '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr(row_reg, col_reg - COL_W'(1));
                            col_next  = col_reg - COL_W'(1);
                        end
                    end
                    K_SET: begin
                        row_next = cmd_reg.row;
                        col_next = cmd_reg.col;
                    end
                    default: begin
                    end
                endcase
                if (wrap) begin
                    col_next = '0;
                    if (!row_last) row_next = row_reg + ROW_W'(1);
                end
            end
            ST_READ_WAIT: begin
                entry_next = ram_rdata;
            end
            ST_SCROLL: begin
                // write the cell fetched last cycle, fetch the one a row below
                ram_we          = pend_reg;
                ram_waddr       = pend_addr_reg;
                ram_wdata       = pend_blank_reg ? BLANK_ENTRY : ram_rdata;
                ram_raddr       = ADDR_W'(32'(sweep_reg) + COLUMNS);
                pend_next       = 1'b1;
                pend_addr_next  = sweep_reg;
                pend_blank_next = !sweep_copy;
                sweep_next      = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            ST_SCROLL_END: begin
                ram_we    = pend_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = pend_blank_reg ? BLANK_ENTRY : ram_rdata;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_entry_next = entry_reg;
                    m_row_next   = ROW_FIELD_W'(row_reg);
                    m_col_next   = COL_FIELD_W'(col_reg);
                    pop          = !q_status.empty;
                end
            end
            default: begin
            end
        endcase

        cmd_next = pop ? q_head : cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            row_reg     <= '0;
            col_reg     <= '0;
            color_reg   <= COLOR_RESET;
            sweep_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            color_reg   <= color_next;
            sweep_reg   <= sweep_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
        entry_reg      <= entry_next;
        m_entry_reg    <= m_entry_next;
        m_row_reg      <= m_row_next;
        m_col_reg      <= m_col_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_entry = m_entry_reg;
    assign m_row_now    = m_row_reg;
    assign m_column_now = m_col_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer: a 30 x 90 store of 16-bit character cells and a cursor.
// Input channel s_*: one command per item (put char, backspace, clear, set
// cursor, read cell). Result channel m_*: one item per command carrying the
// cell read (zero for other commands) and the cursor after the command.
// cfg_wr_en / cfg_wr_data set the foreground color of written characters;
// write it only while no command is in flight.
// Commands pass through a two-entry queue to the executing unit, so input
// items are taken while a result waits on m_ready.
// A command is executed in ST_RUN (a read also passes ST_READ_WAIT) and its
// result is loaded in ST_DONE; the next command is popped only then, as set by
// the execute/result steps of the executing unit around its single-write-port
// cell memory. Clear and scroll sweep the memory one cell per cycle.
// After reset the cell memory is blanked one cell per cycle; s_ready stays
// low meanwhile. Cursor returns to row 0, column 0, color to 7.
// A stalled result holds m_* stable; the queue then fills and s_ready drops.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [COLOR_W-1:0]     cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [CHAR_W-1:0]      s_char_code,
    input  logic [ROW_FIELD_W-1:0] s_target_row,
    input  logic [COL_FIELD_W-1:0] s_target_column,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ENTRY_W-1:0]     m_cell_entry,
    output logic [ROW_FIELD_W-1:0] m_row_now,
    output logic [COL_FIELD_W-1:0] m_column_now
);

    logic          init_busy;
    logic          push;
    logic          pop;
    cmd_t          push_cmd;
    cmd_t          q_head;
    queue_status_t q_status;

    tcw_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_char_code     (s_char_code),
        .s_target_row    (s_target_row),
        .s_target_column (s_target_column),
        .init_busy       (init_busy),
        .q_status        (q_status),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    tcw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .status   (q_status)
    );

    tcw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_head       (q_head),
        .q_status     (q_status),
        .pop          (pop),
        .init_busy    (init_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_entry (m_cell_entry),
        .m_row_now    (m_row_now),
        .m_column_now (m_column_now)
    );

    `TCW_ASSERT_NOW(a_no_accept_in_init, aclk, aresetn, init_busy, !s_ready && !m_valid, "item taken or result shown during memory init")
    `TCW_ASSERT_NOW(a_no_push_full, aclk, aresetn, q_status.full, !push, "push into full queue")
    `TCW_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, q_status.empty, !pop, "pop from empty queue")
    `TCW_ASSERT_NOW(a_cursor_range, aclk, aresetn, m_valid, (32'(m_row_now) < ROWS) && (32'(m_column_now) < COLUMNS), "cursor out of range")

endmodule
